// ===== design/mlfq_pkg.sv =====
// shared types and codes of the multilevel feedback queue scheduler
package mlfq_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int LEVELS     = 8;
  localparam int LIFE_MAX   = 32;

  localparam logic [1:0] ACT_CREATE = 2'd0;
  localparam logic [1:0] ACT_KILL   = 2'd1;
  localparam logic [1:0] ACT_RUN    = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_NOTASK   = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_EXEC,
    OP_APPLY,
    OP_AGE,
    OP_RESULT
  } dp_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_APPLY,
    S_AGE,
    S_RESP
  } state_e;

  typedef struct packed {
    logic run_go;
    logic age_last;
  } dp_stat_t;

endpackage

// ===== design/mlfq_ctrl.sv =====
// sequencer of the scheduler: handshakes and datapath commands
module mlfq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  mlfq_pkg::dp_stat_t stat_i,
  output mlfq_pkg::dp_op_e   op_o
);

  mlfq_pkg::state_e state_q, state_d;
  logic             mvalid_q, mvalid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mlfq_pkg::S_IDLE;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mvalid_q <= mvalid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    op_o    = mlfq_pkg::OP_NONE;
    unique case (state_q)
      mlfq_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          op_o    = mlfq_pkg::OP_LOAD;
          state_d = mlfq_pkg::S_EXEC;
        end
      end
      mlfq_pkg::S_EXEC: begin
        op_o    = mlfq_pkg::OP_EXEC;
        state_d = stat_i.run_go ? mlfq_pkg::S_APPLY : mlfq_pkg::S_RESP;
      end
      mlfq_pkg::S_APPLY: begin
        op_o    = mlfq_pkg::OP_APPLY;
        state_d = mlfq_pkg::S_AGE;
      end
      mlfq_pkg::S_AGE: begin
        op_o = mlfq_pkg::OP_AGE;
        if (stat_i.age_last) state_d = mlfq_pkg::S_RESP;
      end
      mlfq_pkg::S_RESP: begin
        if (!mvalid_q || m_axis_tready) begin
          op_o    = mlfq_pkg::OP_RESULT;
          state_d = mlfq_pkg::S_IDLE;
        end
      end
      default: state_d = mlfq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    if (op_o == mlfq_pkg::OP_RESULT) mvalid_d = 1'b1;
    else if (m_axis_tready)           mvalid_d = 1'b0;
    else                              mvalid_d = mvalid_q;
  end

  assign s_axis_tready = (state_q == mlfq_pkg::S_IDLE);
  assign m_axis_tvalid = mvalid_q;

endmodule

// ===== design/mlfq_dp.sv =====
// datapath of the scheduler: task cells, level counts, time and results
module mlfq_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mlfq_pkg::dp_op_e   op_i,
  output mlfq_pkg::dp_stat_t stat_o,
  input  logic [1:0]         action_i,
  input  logic [3:0]         task_id_i,
  input  logic [2:0]         new_level_i,
  input  logic [5:0]         new_life_i,
  input  logic [2:0]         quantum_jitter_i,
  output logic [1:0]         status_o,
  output logic [3:0]         result_id_o,
  output logic [6:0]         granted_quantum_o,
  output logic [5:0]         ticks_run_o,
  output logic [5:0]         remaining_life_o,
  output logic               completed_o,
  output logic [9:0]         total_life_o,
  output logic [4:0]         promoted_count_o
);

  localparam int TASK_SLOTS = mlfq_pkg::TASK_SLOTS;
  localparam int LEVELS     = mlfq_pkg::LEVELS;
  localparam int LIFE_MAX   = mlfq_pkg::LIFE_MAX;

  localparam int IW  = $clog2(TASK_SLOTS);
  localparam int PW  = IW;
  localparam int CW  = $clog2(TASK_SLOTS + 1);
  localparam int LVW = $clog2(LEVELS);
  localparam int LW  = $clog2(LIFE_MAX + 1);
  localparam int QW  = $clog2(LEVELS * LEVELS + 8);
  localparam int TKW = (LW > QW) ? LW : QW;
  localparam int TW  = $clog2(TASK_SLOTS * LIFE_MAX + 1);

  // task cells
  logic [TASK_SLOTS-1:0] used_q, used_d;
  logic [LVW-1:0]        lvl_q  [TASK_SLOTS];
  logic [LVW-1:0]        lvl_d  [TASK_SLOTS];
  logic [PW-1:0]         pos_q  [TASK_SLOTS];
  logic [PW-1:0]         pos_d  [TASK_SLOTS];
  logic [LW-1:0]         life_q [TASK_SLOTS];
  logic [LW-1:0]         life_d [TASK_SLOTS];
  logic [31:0]           last_q [TASK_SLOTS];
  logic [31:0]           last_d [TASK_SLOTS];
  logic [CW-1:0]         cnt_q  [LEVELS];
  logic [CW-1:0]         cnt_d  [LEVELS];
  logic [31:0]           time_q, time_d;
  logic [TW-1:0]         total_q, total_d;

  // captured transaction
  logic [1:0] act_q, act_d;
  logic [3:0] kid_q, kid_d;
  logic [2:0] nlvl_q, nlvl_d;
  logic [5:0] nlife_q, nlife_d;
  logic [2:0] jit_q, jit_d;

  // run and aging walk
  logic [IW-1:0]  hid_q, hid_d;
  logic [LVW-1:0] hlvl_q, hlvl_d;
  logic [LVW-1:0] alv_q, alv_d;
  logic [CW-1:0]  acur_q, acur_d;

  // result of the step
  logic [1:0]     sts_q, sts_d;
  logic [IW-1:0]  rid_q, rid_d;
  logic [QW-1:0]  qnt_q, qnt_d;
  logic [TKW-1:0] tck_q, tck_d;
  logic [LW-1:0]  rem_q, rem_d;
  logic           done_q, done_d;
  logic [CW-1:0]  promo_q, promo_d;

  // output register
  logic [1:0] osts_q;
  logic [3:0] orid_q;
  logic [6:0] oqnt_q;
  logic [5:0] otck_q, orem_q;
  logic       odone_q;
  logic [9:0] ototal_q;
  logic [4:0] opromo_q;

  logic [IW-1:0]  fid;
  logic           has_free;
  logic [LVW-1:0] rlvl;
  logic           any_ready;
  logic [LVW-1:0] mlvl;
  logic [CW-1:0]  mpos;
  logic           hit;
  logic [IW-1:0]  mid;
  logic [IW-1:0]  kid_ix;
  logic           kid_ok;
  logic [IW-1:0]  rd;
  logic [LVW-1:0] rd_lvl;
  logic [PW-1:0]  rd_pos;
  logic [LW-1:0]  rd_life;
  logic [31:0]    rd_last;
  logic [QW-1:0]  qv;
  logic [TKW-1:0] tv;
  logic [31:0]    ntime;
  logic [LW-1:0]  remv;
  logic [LVW-1:0] down;
  logic [LVW-1:0] cl_lvl;
  logic [LW-1:0]  cl_life;
  logic [31:0]    wt;
  logic           rm_en, ap_en;
  logic [LVW-1:0] rm_lvl, ap_lvl;
  logic [PW-1:0]  rm_pos, ap_pos;
  logic [IW-1:0]  ap_id;

  // lowest free id
  always_comb begin
    fid      = '0;
    has_free = 1'b0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        fid      = IW'(i);
        has_free = 1'b1;
      end
    end
  end

  // first level with a waiting task
  always_comb begin
    rlvl      = '0;
    any_ready = 1'b0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (cnt_q[l] != '0) begin
        rlvl      = LVW'(l);
        any_ready = 1'b1;
      end
    end
  end

  // task at a given level and queue position
  assign mlvl = (op_i == mlfq_pkg::OP_AGE) ? alv_q : rlvl;
  assign mpos = (op_i == mlfq_pkg::OP_AGE) ? acur_q : '0;

  always_comb begin
    hit = 1'b0;
    mid = '0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      if (used_q[i] && lvl_q[i] == mlvl && CW'(pos_q[i]) == mpos) begin
        hit = 1'b1;
        mid = mid | IW'(i);
      end
    end
  end

  assign kid_ix = IW'(kid_q);
  assign kid_ok = (32'(kid_q) < 32'(TASK_SLOTS));

  always_comb begin
    if (op_i == mlfq_pkg::OP_AGE)       rd = mid;
    else if (op_i == mlfq_pkg::OP_EXEC) rd = kid_ix;
    else                                rd = hid_q;
  end

  assign rd_lvl  = lvl_q[rd];
  assign rd_pos  = pos_q[rd];
  assign rd_life = life_q[rd];
  assign rd_last = last_q[rd];

  assign qv    = QW'(jit_q) + QW'(1) + QW'(hlvl_q) * QW'(LEVELS);
  assign tv    = (TKW'(rd_life) < TKW'(qv)) ? TKW'(rd_life) : TKW'(qv);
  assign ntime = time_q + 32'(tv);
  assign remv  = rd_life - LW'(tv);
  assign down  = (hlvl_q == LVW'(LEVELS - 1)) ? hlvl_q : hlvl_q + LVW'(1);
  assign wt    = time_q - rd_last;

  assign cl_lvl = (32'(nlvl_q) < 32'(LEVELS)) ? LVW'(nlvl_q) : LVW'(LEVELS - 1);
  always_comb begin
    if (nlife_q == '0)                        cl_life = LW'(1);
    else if (32'(nlife_q) > 32'(LIFE_MAX))    cl_life = LW'(LIFE_MAX);
    else                                      cl_life = LW'(nlife_q);
  end

  assign ap_pos = PW'(cnt_q[ap_lvl] - CW'(rm_en && rm_lvl == ap_lvl));

  always_comb begin
    used_d  = used_q;
    life_d  = life_q;
    last_d  = last_q;
    time_d  = time_q;
    total_d = total_q;
    act_d   = act_q;
    kid_d   = kid_q;
    nlvl_d  = nlvl_q;
    nlife_d = nlife_q;
    jit_d   = jit_q;
    hid_d   = hid_q;
    hlvl_d  = hlvl_q;
    alv_d   = alv_q;
    acur_d  = acur_q;
    sts_d   = sts_q;
    rid_d   = rid_q;
    qnt_d   = qnt_q;
    tck_d   = tck_q;
    rem_d   = rem_q;
    done_d  = done_q;
    promo_d = promo_q;
    rm_en   = 1'b0;
    rm_lvl  = '0;
    rm_pos  = '0;
    ap_en   = 1'b0;
    ap_lvl  = '0;
    ap_id   = '0;

    unique case (op_i)
      mlfq_pkg::OP_LOAD: begin
        act_d   = action_i;
        kid_d   = task_id_i;
        nlvl_d  = new_level_i;
        nlife_d = new_life_i;
        jit_d   = quantum_jitter_i;
      end
      mlfq_pkg::OP_EXEC: begin
        sts_d   = mlfq_pkg::ST_OK;
        rid_d   = '0;
        qnt_d   = '0;
        tck_d   = '0;
        rem_d   = '0;
        done_d  = 1'b0;
        promo_d = '0;
        unique case (act_q)
          mlfq_pkg::ACT_CREATE: begin
            if (!has_free) begin
              sts_d = mlfq_pkg::ST_FULL;
            end else begin
              used_d[fid] = 1'b1;
              life_d[fid] = cl_life;
              last_d[fid] = time_q;
              total_d     = total_q + TW'(cl_life);
              ap_en       = 1'b1;
              ap_id       = fid;
              ap_lvl      = cl_lvl;
              rid_d       = fid;
            end
          end
          mlfq_pkg::ACT_KILL: begin
            if (kid_ok && used_q[kid_ix]) begin
              rm_en          = 1'b1;
              rm_lvl         = rd_lvl;
              rm_pos         = rd_pos;
              used_d[kid_ix] = 1'b0;
              total_d        = total_q - TW'(rd_life);
              rid_d          = kid_ix;
            end else begin
              sts_d = mlfq_pkg::ST_NOTFOUND;
            end
          end
          mlfq_pkg::ACT_RUN: begin
            if (!any_ready) begin
              sts_d = mlfq_pkg::ST_NOTASK;
            end else begin
              hid_d  = mid;
              hlvl_d = rlvl;
            end
          end
          default: ;
        endcase
      end
      mlfq_pkg::OP_APPLY: begin
        time_d        = ntime;
        last_d[hid_q] = ntime;
        life_d[hid_q] = remv;
        total_d       = total_q - TW'(tv);
        rm_en         = 1'b1;
        rm_lvl        = hlvl_q;
        rm_pos        = '0;
        if (remv == '0) begin
          used_d[hid_q] = 1'b0;
          done_d        = 1'b1;
        end else begin
          ap_en  = 1'b1;
          ap_id  = hid_q;
          ap_lvl = down;
        end
        qnt_d   = qv;
        tck_d   = tv;
        rem_d   = remv;
        rid_d   = hid_q;
        alv_d   = LVW'(1);
        acur_d  = '0;
        promo_d = '0;
      end
      mlfq_pkg::OP_AGE: begin
        if (hit) begin
          if (wt >= 32'({rd_life, 1'b0})) begin
            rm_en       = 1'b1;
            rm_lvl      = alv_q;
            rm_pos      = PW'(acur_q);
            ap_en       = 1'b1;
            ap_id       = mid;
            ap_lvl      = alv_q - LVW'(1);
            last_d[mid] = time_q;
            promo_d     = promo_q + CW'(1);
          end else begin
            acur_d = acur_q + CW'(1);
          end
        end else if (alv_q != LVW'(LEVELS - 1)) begin
          alv_d  = alv_q + LVW'(1);
          acur_d = '0;
        end
      end
      default: ;
    endcase
  end

  // queue moves applied to every cell at once
  always_comb begin
    for (int i = 0; i < TASK_SLOTS; i++) begin
      lvl_d[i] = lvl_q[i];
      pos_d[i] = pos_q[i];
      if (ap_en && ap_id == IW'(i)) begin
        lvl_d[i] = ap_lvl;
        pos_d[i] = ap_pos;
      end else if (rm_en && used_q[i] && lvl_q[i] == rm_lvl && pos_q[i] > rm_pos) begin
        pos_d[i] = pos_q[i] - PW'(1);
      end
    end
    for (int l = 0; l < LEVELS; l++) begin
      cnt_d[l] = cnt_q[l] - CW'(rm_en && rm_lvl == LVW'(l))
                          + CW'(ap_en && ap_lvl == LVW'(l));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      time_q  <= '0;
      total_q <= '0;
      for (int l = 0; l < LEVELS; l++) cnt_q[l] <= '0;
    end else begin
      used_q  <= used_d;
      time_q  <= time_d;
      total_q <= total_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q   <= lvl_d;
    pos_q   <= pos_d;
    life_q  <= life_d;
    last_q  <= last_d;
    act_q   <= act_d;
    kid_q   <= kid_d;
    nlvl_q  <= nlvl_d;
    nlife_q <= nlife_d;
    jit_q   <= jit_d;
    hid_q   <= hid_d;
    hlvl_q  <= hlvl_d;
    alv_q   <= alv_d;
    acur_q  <= acur_d;
    sts_q   <= sts_d;
    rid_q   <= rid_d;
    qnt_q   <= qnt_d;
    tck_q   <= tck_d;
    rem_q   <= rem_d;
    done_q  <= done_d;
    promo_q <= promo_d;
    if (op_i == mlfq_pkg::OP_RESULT) begin
      osts_q   <= sts_q;
      orid_q   <= 4'(rid_q);
      oqnt_q   <= 7'(qnt_q);
      otck_q   <= 6'(tck_q);
      orem_q   <= 6'(rem_q);
      odone_q  <= done_q;
      ototal_q <= (32'(total_q) > 32'd1023) ? 10'd1023 : 10'(total_q);
      opromo_q <= (32'(promo_q) > 32'd31) ? 5'd31 : 5'(promo_q);
    end
  end

  assign stat_o.run_go   = (act_q == mlfq_pkg::ACT_RUN) && any_ready;
  assign stat_o.age_last = !hit && (alv_q == LVW'(LEVELS - 1));

  assign status_o          = osts_q;
  assign result_id_o       = orid_q;
  assign granted_quantum_o = oqnt_q;
  assign ticks_run_o       = otck_q;
  assign remaining_life_o  = orem_q;
  assign completed_o       = odone_q;
  assign total_life_o      = ototal_q;
  assign promoted_count_o  = opromo_q;

endmodule

// ===== design/multilevel_feedback_queue_scheduler_top.sv =====
// top level of the multilevel feedback queue scheduler with aging
//
// usage: one command transaction in on the s_axis side, one result transaction
// out on the m_axis side for every command. s_axis_tuser carries the action
// (create, kill, run one slice), s_axis_tdata the task id, level, life and
// quantum jitter. m_axis_tuser carries the status code, m_axis_tdata the
// result id, quantum, ticks run, remaining life, completed flag, total life
// and the count of tasks promoted by aging.
// sequence: create, kill, unused codes and a run with no waiting task go from
// exec straight to the result; a run slice first applies the slice, then walks
// aging, which visits every waiting task of levels 1 and up once.
// one command is handled at a time; s_axis_tready is high while idle, and a
// new command is taken while the previous result still waits in the output
// register. if the receiver stalls, the next result waits until it is taken.
// reset empties all queues, frees every id and clears system time; no
// clearing pass is needed.
module multilevel_feedback_queue_scheduler_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // task_id[3:0], new_level[6:4], new_life[12:7], quantum_jitter[15:13]
  input  logic [15:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result_id[3:0], granted_quantum[10:4], ticks_run[16:11],
  // remaining_life[22:17], completed[23], total_life[33:24],
  // promoted_count[38:34], zero fill[39]
  output logic [39:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]  m_axis_tuser
);

  mlfq_pkg::dp_op_e   op;
  mlfq_pkg::dp_stat_t stat;

  logic [3:0] rid;
  logic [6:0] qnt;
  logic [5:0] tck;
  logic [5:0] rem;
  logic       done;
  logic [9:0] total;
  logic [4:0] promo;

  // sequencer
  mlfq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .stat_i        (stat),
    .op_o          (op)
  );

  // task table, queues and result register
  mlfq_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .op_i              (op),
    .stat_o            (stat),
    .action_i          (s_axis_tuser),
    .task_id_i         (s_axis_tdata[3:0]),
    .new_level_i       (s_axis_tdata[6:4]),
    .new_life_i        (s_axis_tdata[12:7]),
    .quantum_jitter_i  (s_axis_tdata[15:13]),
    .status_o          (m_axis_tuser),
    .result_id_o       (rid),
    .granted_quantum_o (qnt),
    .ticks_run_o       (tck),
    .remaining_life_o  (rem),
    .completed_o       (done),
    .total_life_o      (total),
    .promoted_count_o  (promo)
  );

  assign m_axis_tdata = {1'b0, promo, total, done, rem, tck, qnt, rid};

  // one command at a time: no second accept right after an accept
  a_single_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("command accepted while busy");

  // a released task has no life left
  a_done_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && done) |-> (rem == 6'd0 && m_axis_tuser == mlfq_pkg::ST_OK))
    else $error("completed task with remaining life");

  // a failed run reports no slice and no aging
  a_notask_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == mlfq_pkg::ST_NOTASK)
      |-> (tck == 6'd0 && qnt == 7'd0 && promo == 5'd0 && !done))
    else $error("slice fields set without a runnable task");

endmodule

// ===== verif/tb_multilevel_feedback_queue_scheduler_top.sv =====
// testbench of the multilevel feedback queue scheduler: directed table, table fill, then random commands
`timescale 1ns / 100ps

module tb_multilevel_feedback_queue_scheduler_top;

  localparam int SLOTS = mlfq_pkg::TASK_SLOTS;
  localparam int LVLS = mlfq_pkg::LEVELS;
  localparam int LMAX = mlfq_pkg::LIFE_MAX;
  localparam int NIL = SLOTS;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_CMDS = 1100;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] task_id;
    logic [2:0] new_level;
    logic [5:0] new_life;
    logic [2:0] jitter;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] result_id;
    logic [6:0] quantum;
    logic [5:0] ticks;
    logic [5:0] remain;
    logic       completed;
    logic [9:0] total_life;
    logic [4:0] promoted;
  } sched_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  always #4 clk_i = ~clk_i;

  multilevel_feedback_queue_scheduler_top dut (.*);

  // scheduler shadow state
  bit          used_q [SLOTS];
  int unsigned lvl_q [SLOTS];
  int unsigned life_q [SLOTS];
  logic [31:0] stamp_q [SLOTS];
  int unsigned link_q [SLOTS];
  int unsigned head_q [LVLS];
  int unsigned tail_q [LVLS];
  logic [31:0] sched_now;
  int unsigned life_sum;

  sched_result_t pending_results[$];
  int errors = 0;
  int n_results = 0;
  int n_done = 0;
  int n_promo = 0;
  bit stim_done = 0;

  function automatic void shadow_reset();
    for (int i = 0; i < SLOTS; i++) begin
      used_q[i] = 0; link_q[i] = NIL;
    end
    for (int i = 0; i < LVLS; i++) begin
      head_q[i] = NIL; tail_q[i] = NIL;
    end
    sched_now = '0;
    life_sum = 0;
  endfunction

  function automatic void enqueue(int unsigned l, int unsigned id);
    link_q[id] = NIL;
    if (head_q[l] >= SLOTS) head_q[l] = id;
    else link_q[tail_q[l]] = id;
    tail_q[l] = id;
  endfunction

  function automatic void unlink(int unsigned l, int unsigned id);
    int unsigned prv, cur, n;
    prv = NIL; cur = head_q[l]; n = 0;
    while (cur < SLOTS && n < SLOTS) begin
      if (cur == id) begin
        if (prv >= SLOTS) head_q[l] = link_q[cur];
        else link_q[prv] = link_q[cur];
        if (tail_q[l] == cur) tail_q[l] = prv;
        return;
      end
      prv = cur; cur = link_q[cur]; n++;
    end
  endfunction

  // walk levels 1 and up, move long waiters one level up
  function automatic int unsigned age_tasks();
    int unsigned cnt, cur, nxt, n;
    logic [31:0] waited;
    cnt = 0;
    for (int unsigned l = 1; l < LVLS; l++) begin
      cur = head_q[l]; n = 0;
      while (cur < SLOTS && n < SLOTS) begin
        nxt = link_q[cur];
        waited = sched_now - stamp_q[cur];
        if (waited >= 32'(2 * life_q[cur])) begin
          unlink(l, cur);
          enqueue(l - 1, cur);
          stamp_q[cur] = sched_now;
          lvl_q[cur] = l - 1;
          cnt++;
        end
        cur = nxt; n++;
      end
    end
    return cnt;
  endfunction

  function automatic sched_result_t schedule(cmd_t c);
    sched_result_t r;
    int unsigned id, l, lf, q, tk, rem, promo;
    r = '0; promo = 0;
    case (c.action)
      mlfq_pkg::ACT_CREATE: begin
        id = 0;
        while (id < SLOTS && used_q[id]) id++;
        if (id >= SLOTS) r.status = mlfq_pkg::ST_FULL;
        else begin
          l = (c.new_level < LVLS) ? c.new_level : LVLS - 1;
          lf = (c.new_life == 0) ? 1 : c.new_life;
          if (lf > LMAX) lf = LMAX;
          used_q[id] = 1; lvl_q[id] = l; life_q[id] = lf; stamp_q[id] = sched_now;
          life_sum += lf;
          enqueue(l, id);
          r.result_id = 4'(id);
        end
      end
      mlfq_pkg::ACT_KILL: begin
        if (used_q[c.task_id]) begin
          unlink(lvl_q[c.task_id], c.task_id);
          used_q[c.task_id] = 0;
          life_sum -= life_q[c.task_id];
          r.result_id = c.task_id;
        end else r.status = mlfq_pkg::ST_NOTFOUND;
      end
      mlfq_pkg::ACT_RUN: begin
        l = 0;
        while (l < LVLS && head_q[l] >= SLOTS) l++;
        if (l >= LVLS) r.status = mlfq_pkg::ST_NOTASK;
        else begin
          id = head_q[l];
          q = c.jitter + 1 + l * LVLS;
          tk = (life_q[id] < q) ? life_q[id] : q;
          sched_now += tk;
          stamp_q[id] = sched_now;
          rem = life_q[id] - tk;
          life_q[id] = rem;
          life_sum -= tk;
          unlink(l, id);
          if (rem == 0) begin
            used_q[id] = 0; r.completed = 1'b1;
          end else begin
            lvl_q[id] = (l + 1 > LVLS - 1) ? LVLS - 1 : l + 1;
            enqueue(lvl_q[id], id);
          end
          r.result_id = 4'(id); r.quantum = 7'(q); r.ticks = 6'(tk); r.remain = 6'(rem);
          promo = age_tasks();
        end
      end
      default: ;
    endcase
    r.total_life = (life_sum > 1023) ? 10'd1023 : 10'(life_sum);
    r.promoted = (promo > 31) ? 5'd31 : 5'(promo);
    return r;
  endfunction

  function automatic int unsigned live_count();
    int unsigned n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) n += used_q[i];
    return n;
  endfunction

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // called at a falling edge; leaves at the falling edge after the accept
  task automatic send(cmd_t c);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata <= {c.jitter, c.new_life, c.new_level, c.task_id};
    s_axis_tuser <= c.action;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(schedule(c));
    @(negedge clk_i);
  endtask

  function automatic cmd_t mk(logic [1:0] a, int id, int l, int lf, int j);
    cmd_t c;
    c.action = a; c.task_id = 4'(id); c.new_level = 3'(l); c.new_life = 6'(lf);
    c.jitter = 3'(j);
    return c;
  endfunction

  // receiver stalls at random
  initial begin
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 49) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(negedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
      end
    end
  end

  // compare every result transaction with the oldest prediction
  always @(posedge clk_i) begin
    sched_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[10:4], m_axis_tdata[16:11],
             m_axis_tdata[22:17], m_axis_tdata[23], m_axis_tdata[33:24],
             m_axis_tdata[38:34]};
      if (pending_results.size() == 0) begin
        $error("result transaction with no command waiting");
        errors++;
      end else begin
        want = pending_results.pop_front();
        n_results++;
        n_done += got.completed;
        n_promo += got.promoted;
        if (got.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, got.status); errors++;
        end
        if (got.result_id !== want.result_id) begin
          $error("result_id expected %0d got %0d", want.result_id, got.result_id); errors++;
        end
        if (got.quantum !== want.quantum) begin
          $error("granted_quantum expected %0d got %0d", want.quantum, got.quantum); errors++;
        end
        if (got.ticks !== want.ticks) begin
          $error("ticks_run expected %0d got %0d", want.ticks, got.ticks); errors++;
        end
        if (got.remain !== want.remain) begin
          $error("remaining_life expected %0d got %0d", want.remain, got.remain); errors++;
        end
        if (got.completed !== want.completed) begin
          $error("completed expected %0d got %0d", want.completed, got.completed); errors++;
        end
        if (got.total_life !== want.total_life) begin
          $error("total_life expected %0d got %0d", want.total_life, got.total_life);
          errors++;
        end
        if (got.promoted !== want.promoted) begin
          $error("promoted_count expected %0d got %0d", want.promoted, got.promoted);
          errors++;
        end
        if (m_axis_tdata[39] !== 1'b0) begin
          $error("zero fill expected 0 got %b", m_axis_tdata[39]); errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle = 0;
      else if (rst_ni) idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // directed rows: commands with hand-typed expectations where obvious
  typedef struct {
    cmd_t c;
    bit   typed;
    logic [1:0] status;
    logic [3:0] id;
  } row_t;

  row_t dir_rows[$];

  initial begin
    cmd_t c;
    int unsigned r;
    shadow_reset();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    dir_rows = '{
      '{mk(mlfq_pkg::ACT_RUN, 0, 0, 0, 0), 1'b1, mlfq_pkg::ST_NOTASK, 4'd0},   // empty table
      '{mk(mlfq_pkg::ACT_KILL, 15, 0, 0, 0), 1'b1, mlfq_pkg::ST_NOTFOUND, 4'd0}, // free id
      '{mk(ACT_UNUSED, 15, 7, 63, 7), 1'b1, mlfq_pkg::ST_OK, 4'd0},             // unused code
      '{mk(mlfq_pkg::ACT_CREATE, 0, 0, 0, 0), 1'b1, mlfq_pkg::ST_OK, 4'd0},     // life 0 to 1
      '{mk(mlfq_pkg::ACT_CREATE, 0, 7, 63, 7), 1'b1, mlfq_pkg::ST_OK, 4'd1},    // life above max
      '{mk(mlfq_pkg::ACT_CREATE, 0, 3, 32, 0), 1'b1, mlfq_pkg::ST_OK, 4'd2},
      '{mk(mlfq_pkg::ACT_CREATE, 0, 7, 1, 0), 1'b1, mlfq_pkg::ST_OK, 4'd3},
      '{mk(mlfq_pkg::ACT_RUN, 0, 0, 0, 7), 1'b0, mlfq_pkg::ST_OK, 4'd0},
      '{mk(mlfq_pkg::ACT_RUN, 0, 0, 0, 0), 1'b0, mlfq_pkg::ST_OK, 4'd0},
      '{mk(mlfq_pkg::ACT_KILL, 2, 0, 0, 0), 1'b1, mlfq_pkg::ST_OK, 4'd2},
      '{mk(mlfq_pkg::ACT_KILL, 2, 0, 0, 0), 1'b1, mlfq_pkg::ST_NOTFOUND, 4'd0},
      '{mk(mlfq_pkg::ACT_RUN, 0, 0, 0, 7), 1'b0, mlfq_pkg::ST_OK, 4'd0},
      '{mk(mlfq_pkg::ACT_RUN, 0, 0, 0, 7), 1'b0, mlfq_pkg::ST_OK, 4'd0},
      '{mk(mlfq_pkg::ACT_RUN, 0, 0, 0, 7), 1'b0, mlfq_pkg::ST_OK, 4'd0},
      '{mk(mlfq_pkg::ACT_RUN, 0, 0, 0, 3), 1'b0, mlfq_pkg::ST_OK, 4'd0},
      '{mk(mlfq_pkg::ACT_RUN, 0, 0, 0, 0), 1'b0, mlfq_pkg::ST_OK, 4'd0}
    };
    foreach (dir_rows[i]) begin
      send(dir_rows[i].c);
      if (dir_rows[i].typed && (pending_results[$].status !== dir_rows[i].status ||
          pending_results[$].result_id !== dir_rows[i].id)) begin
        $error("row %0d: predictor disagrees with typed status/id", i);
        errors++;
      end
    end
    // fill to the brim, then one more create must report table full
    while (live_count() < SLOTS) begin
      send(mk(mlfq_pkg::ACT_CREATE, 0, $urandom_range(0, 7), 32, 0));
    end
    send(mk(mlfq_pkg::ACT_CREATE, 0, 0, 5, 0));
    if (pending_results[$].status !== mlfq_pkg::ST_FULL) begin
      $error("full table row: predictor disagrees"); errors++;
    end
    for (int i = 0; i < SLOTS; i++) send(mk(mlfq_pkg::ACT_KILL, i, 0, 0, 0));

    // random part: mostly create/run mixes that keep the table busy
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      c = cmd_t'(18'($urandom));
      r = $urandom_range(0, 99);
      if (r < 40) c.action = mlfq_pkg::ACT_CREATE;
      else if (r < 52) c.action = mlfq_pkg::ACT_KILL;
      else if (r < 97) c.action = mlfq_pkg::ACT_RUN;
      else c.action = ACT_UNUSED;
      if ($urandom_range(0, 2) != 0) c.new_life = 6'($urandom_range(1, 12));
      if (n == RANDOM_CMDS / 2) begin
        s_axis_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        @(negedge clk_i);
      end
      send(c);
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    wait (pending_results.size() == 0);
    repeat (2 * (SLOTS + LVLS + 3)) @(posedge clk_i);
    $display("covered %0d results: %0d tasks completed, %0d aging promotions",
             n_results, n_done, n_promo);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mlfq_pkg.sv
design/mlfq_ctrl.sv
design/mlfq_dp.sv
design/multilevel_feedback_queue_scheduler_top.sv
verif/tb_multilevel_feedback_queue_scheduler_top.sv
